[rtl/core/tpc_pkg.sv]
`timescale 1ns / 1ps
// shared types, codes and sizes for the trusted proxy cidr table
package tpc_pkg;

    localparam int MAX_RULES = 8;
    localparam int CNT_W     = $clog2(MAX_RULES + 1);
    localparam int WALK_W    = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int ADDR_W    = 128;
    localparam int V4_BITS   = 32;
    localparam int V6_BITS   = 128;

    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_ADD     = 2'd1;
    localparam logic [1:0] CMD_RESOLVE = 2'd2;

    localparam logic [1:0] FAM_NONE = 2'd0;
    localparam logic [1:0] FAM_V4   = 2'd1;
    localparam logic [1:0] FAM_V6   = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EMIT
    } t_state;

    // lookup probe travelling down the cell chain
    typedef struct packed {
        logic [1:0]        family;
        logic [ADDR_W-1:0] addr;
        logic              hit;
    } t_probe;

    // rule write bus shared by all cells
    typedef struct packed {
        logic [1:0]        family;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] mask;
    } t_rule;

endpackage

[rtl/core/tpc_cell.sv]
`timescale 1ns / 1ps
// one rule slot of the chain: holds a rule and tests the passing probe
module tpc_cell (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  tpc_pkg::t_rule  i_wr_rule,
    input  logic            i_enabled,
    input  tpc_pkg::t_probe i_probe,
    output tpc_pkg::t_probe o_probe
);

    logic [1:0]                 r_family;
    logic [tpc_pkg::ADDR_W-1:0] r_addr;
    logic [tpc_pkg::ADDR_W-1:0] r_mask;
    tpc_pkg::t_probe            r_probe;
    tpc_pkg::t_probe            n_probe;
    logic                       w_match;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_family <= i_wr_rule.family;
            r_addr   <= i_wr_rule.addr;
            r_mask   <= i_wr_rule.mask;
        end
        r_probe <= n_probe;
    end

    // masked compare on an enabled cell, family must agree
    assign w_match = i_enabled && (r_family == i_probe.family) &&
                     (((i_probe.addr ^ r_addr) & r_mask) == '0);

    always_comb begin
        n_probe     = i_probe;
        n_probe.hit = i_probe.hit | w_match;
    end

    assign o_probe = r_probe;

endmodule

[rtl/core/trusted_proxy_cidr_table.sv]
`timescale 1ns / 1ps
// top level of the trusted proxy cidr table: control, rule writes and cell chain
//
// usage
//   input channel (i_in_valid / o_in_stall) carries one command item: clear,
//   add rule or resolve peer. output channel (o_out_valid / i_out_stall)
//   returns exactly one result item for every accepted item, in order
//   rules live in a chain of MAX_RULES cells, one rule each. a resolve item
//   sends a probe down the chain, one cell per cycle, picking up a hit flag
// sequencing
//   clear / add: idle, then emit, which loads the output register once it is
//   free. resolve: idle, then walk while the probe crosses the cell chain,
//   then emit. a new item is taken only in idle, so each result is in the
//   output register before the next item is accepted
// reset
//   synchronous, active low: rule count cleared (table empty), no result
//   pending, control back to idle. rule contents are not cleared
// stall
//   a result waits in the output register while i_out_stall is high; the
//   block still accepts one new item and holds its result until the output
//   register frees up
module trusted_proxy_cidr_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [1:0]  i_addr_family,
    input  logic [63:0] i_addr_high,
    input  logic [63:0] i_addr_low,
    input  logic [7:0]  i_prefix_bits,
    input  logic        i_fwd_present,
    input  logic [1:0]  i_fwd_family,
    input  logic [63:0] i_fwd_high,
    input  logic [63:0] i_fwd_low,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_accepted,
    output logic        o_peer_trusted,
    output logic [1:0]  o_out_family,
    output logic [63:0] o_out_high,
    output logic [63:0] o_out_low
);

    localparam int N = tpc_pkg::MAX_RULES;

    // control state
    tpc_pkg::t_state              r_state;
    tpc_pkg::t_state              n_state;
    logic [tpc_pkg::CNT_W-1:0]    r_count;
    logic [tpc_pkg::WALK_W-1:0]   r_walk;
    logic                         r_out_valid;

    // captured item
    logic [1:0]                   r_cmd;
    logic [1:0]                   r_fam;
    logic [tpc_pkg::ADDR_W-1:0]   r_addr;
    logic                         r_fwd_present;
    logic [1:0]                   r_fwd_fam;
    logic [tpc_pkg::ADDR_W-1:0]   r_fwd_addr;
    logic                         r_add_ok;
    logic                         r_hit;

    // output register
    logic                         r_o_accepted;
    logic                         r_o_trusted;
    logic [1:0]                   r_o_family;
    logic [tpc_pkg::ADDR_W-1:0]   r_o_addr;

    // strobes from the fsm output block, plus the output-free flag
    logic                         w_take;
    logic                         w_walk_end;
    logic                         w_load_out;
    logic                         w_out_free;

    // normalised query and rule
    logic [1:0]                   w_q_fam;
    logic [tpc_pkg::ADDR_W-1:0]   w_q_addr;
    logic                         w_add_ok;
    tpc_pkg::t_rule               w_rule;
    tpc_pkg::t_probe              w_probe_head;
    tpc_pkg::t_probe              w_chain [N+1];

    // result assembly
    logic [tpc_pkg::ADDR_W-1:0]   w_fwd_norm;
    logic                         w_use_fwd;
    logic                         n_o_accepted;
    logic                         n_o_trusted;
    logic [1:0]                   n_o_family;
    logic [tpc_pkg::ADDR_W-1:0]   n_o_addr;

    assign w_out_free = !r_out_valid || !i_out_stall;

    // peer address: ipv4 keeps low 32 bits, unknown family collapses to zero
    always_comb begin
        case (i_addr_family)
            tpc_pkg::FAM_V4: begin
                w_q_fam  = tpc_pkg::FAM_V4;
                w_q_addr = {96'd0, i_addr_low[31:0]};
            end
            tpc_pkg::FAM_V6: begin
                w_q_fam  = tpc_pkg::FAM_V6;
                w_q_addr = {i_addr_high, i_addr_low};
            end
            default: begin
                w_q_fam  = tpc_pkg::FAM_NONE;
                w_q_addr = '0;
            end
        endcase
    end

    // rule check and prefix mask built once, at add time
    always_comb begin
        w_rule.family = i_addr_family;
        w_rule.addr   = w_q_addr;
        case (i_addr_family)
            tpc_pkg::FAM_V4: begin
                w_add_ok    = ({1'b0, i_prefix_bits} <= 9'(tpc_pkg::V4_BITS));
                w_rule.mask = {96'd0, ~(32'hFFFF_FFFF >> i_prefix_bits)};
            end
            tpc_pkg::FAM_V6: begin
                w_add_ok    = ({1'b0, i_prefix_bits} <= 9'(tpc_pkg::V6_BITS));
                w_rule.mask = ~({tpc_pkg::ADDR_W{1'b1}} >> i_prefix_bits);
            end
            default: begin
                w_add_ok    = 1'b0;
                w_rule.mask = '0;
            end
        endcase
        w_add_ok = w_add_ok && (r_count < tpc_pkg::CNT_W'(N));
    end

    always_comb begin
        w_probe_head.family = w_q_fam;
        w_probe_head.addr   = w_q_addr;
        w_probe_head.hit    = 1'b0;
    end

    assign w_chain[0] = w_probe_head;

    // cell chain, cell k holds rule k
    for (genvar k = 0; k < N; k++) begin : g_cell
        tpc_cell u_cell (
            .i_clk     (i_clk),
            .i_wr_en   (w_take && (i_cmd == tpc_pkg::CMD_ADD) && w_add_ok &&
                        (r_count == tpc_pkg::CNT_W'(k))),
            .i_wr_rule (w_rule),
            .i_enabled (r_count > tpc_pkg::CNT_W'(k)),
            .i_probe   (w_chain[k]),
            .o_probe   (w_chain[k+1])
        );
    end

    // fsm next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tpc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_cmd == tpc_pkg::CMD_RESOLVE) ? tpc_pkg::S_WALK
                                                              : tpc_pkg::S_EMIT;
                end
            end
            tpc_pkg::S_WALK: begin
                if (r_walk == tpc_pkg::WALK_W'(N - 1)) begin
                    n_state = tpc_pkg::S_EMIT;
                end
            end
            tpc_pkg::S_EMIT: begin
                if (w_out_free) begin
                    n_state = tpc_pkg::S_IDLE;
                end
            end
            default: n_state = tpc_pkg::S_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_take     = 1'b0;
        w_walk_end = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            tpc_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                w_take     = i_in_valid;
            end
            tpc_pkg::S_WALK: begin
                w_walk_end = (r_walk == tpc_pkg::WALK_W'(N - 1));
            end
            tpc_pkg::S_EMIT: begin
                w_load_out = w_out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tpc_pkg::S_IDLE;
            r_count     <= '0;
            r_walk      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_take) begin
                r_walk <= '0;
            end else if (r_state == tpc_pkg::S_WALK) begin
                r_walk <= r_walk + 1'b1;
            end
            if (w_take && (i_cmd == tpc_pkg::CMD_CLEAR)) begin
                r_count <= '0;
            end else if (w_take && (i_cmd == tpc_pkg::CMD_ADD) && w_add_ok) begin
                r_count <= r_count + 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd         <= i_cmd;
            r_fam         <= w_q_fam;
            r_addr        <= w_q_addr;
            r_fwd_present <= i_fwd_present;
            r_fwd_fam     <= i_fwd_family;
            r_fwd_addr    <= {i_fwd_high, i_fwd_low};
            r_add_ok      <= w_add_ok;
        end
        if (w_walk_end) begin
            r_hit <= w_chain[N].hit;
        end
    end

    // forwarded address: ipv4 keeps low 32 bits only
    assign w_fwd_norm = (r_fwd_fam == tpc_pkg::FAM_V4) ? {96'd0, r_fwd_addr[31:0]}
                                                       : r_fwd_addr;
    assign w_use_fwd  = r_hit && r_fwd_present &&
                        ((r_fwd_fam == tpc_pkg::FAM_V4) || (r_fwd_fam == tpc_pkg::FAM_V6)) &&
                        (w_fwd_norm != '0);

    always_comb begin
        n_o_accepted = 1'b0;
        n_o_trusted  = 1'b0;
        n_o_family   = tpc_pkg::FAM_NONE;
        n_o_addr     = '0;
        case (r_cmd)
            tpc_pkg::CMD_CLEAR: n_o_accepted = 1'b1;
            tpc_pkg::CMD_ADD:   n_o_accepted = r_add_ok;
            tpc_pkg::CMD_RESOLVE: begin
                n_o_trusted  = r_hit;
                n_o_accepted = w_use_fwd;
                n_o_family   = w_use_fwd ? r_fwd_fam : r_fam;
                n_o_addr     = w_use_fwd ? w_fwd_norm : r_addr;
            end
            default: n_o_accepted = 1'b0;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_o_accepted <= n_o_accepted;
            r_o_trusted  <= n_o_trusted;
            r_o_family   <= n_o_family;
            r_o_addr     <= n_o_addr;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_accepted     = r_o_accepted;
    assign o_peer_trusted = r_o_trusted;
    assign o_out_family   = r_o_family;
    assign o_out_high     = r_o_addr[127:64];
    assign o_out_low      = r_o_addr[63:0];

endmodule

[sim/trusted_proxy_cidr_table_test.sv]
`timescale 1ns / 1ps
// self-checking testbench for the trusted proxy cidr table: directed and random command items
module trusted_proxy_cidr_table_test;

    // codes outside the defined command and family ranges
    localparam logic [1:0]  CMD_UNUSED = 2'd3;
    localparam logic [1:0]  FAM_BAD    = 2'd3;
    localparam logic [63:0] ONES       = 64'hFFFF_FFFF_FFFF_FFFF;

    // one command item as it crosses the input channel
    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  addr_family;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [7:0]  prefix_bits;
        logic        fwd_present;
        logic [1:0]  fwd_family;
        logic [63:0] fwd_high;
        logic [63:0] fwd_low;
    } t_cmd_item;

    // one result item as it leaves the output channel
    typedef struct packed {
        logic        accepted;
        logic        trusted;
        logic [1:0]  family;
        logic [63:0] high;
        logic [63:0] low;
    } t_verdict;

    // rule table mirror, verdict prediction and in-order result checking
    class cidr_scoreboard;
        logic [1:0]   rule_fam  [tpc_pkg::MAX_RULES];
        logic [127:0] rule_addr [tpc_pkg::MAX_RULES];
        logic [7:0]   rule_len  [tpc_pkg::MAX_RULES];
        int unsigned  rules_held;
        t_verdict     outstanding[$];
        int unsigned  n_bad, n_results;
        int unsigned  n_clear, n_add, n_stored, n_resolve, n_trusted, n_forwarded, n_unused;

        // top len bits of a w-bit address set, the address sitting in the low w bits
        static function logic [127:0] lead_mask(input logic [7:0] len, input int unsigned w);
            if (len == 0)
                return '0;
            return (~128'd0 << (w - len)) & (~128'd0 >> (128 - w));
        endfunction

        function void note_input(input t_cmd_item it);
            t_verdict     want;
            logic [127:0] peer;
            logic [127:0] fwd;
            logic [1:0]   pfam;
            logic         hit;
            int unsigned  w;
            want = '0;
            case (it.cmd)
                tpc_pkg::CMD_CLEAR: begin
                    rules_held = 0;
                    want.accepted = 1'b1;
                    n_clear++;
                end
                tpc_pkg::CMD_ADD: begin
                    n_add++;
                    w = (it.addr_family == tpc_pkg::FAM_V4) ? tpc_pkg::V4_BITS :
                        (it.addr_family == tpc_pkg::FAM_V6) ? tpc_pkg::V6_BITS : 0;
                    if (w != 0 && it.prefix_bits <= w && rules_held < tpc_pkg::MAX_RULES) begin
                        rule_fam[rules_held]  = it.addr_family;
                        rule_len[rules_held]  = it.prefix_bits;
                        rule_addr[rules_held] = (it.addr_family == tpc_pkg::FAM_V4) ?
                            {96'd0, it.addr_low[31:0]} : {it.addr_high, it.addr_low};
                        rules_held++;
                        want.accepted = 1'b1;
                        n_stored++;
                    end
                end
                tpc_pkg::CMD_RESOLVE: begin
                    n_resolve++;
                    pfam = it.addr_family;
                    peer = {it.addr_high, it.addr_low};
                    if (pfam == tpc_pkg::FAM_V4) begin
                        peer = {96'd0, it.addr_low[31:0]};
                    end else if (pfam != tpc_pkg::FAM_V6) begin
                        pfam = tpc_pkg::FAM_NONE;
                        peer = '0;
                    end
                    hit = 1'b0;
                    if (pfam != tpc_pkg::FAM_NONE)
                        for (int i = 0; i < rules_held; i++)
                            if (rule_fam[i] == pfam && ((peer ^ rule_addr[i]) &
                                lead_mask(rule_len[i], (pfam == tpc_pkg::FAM_V4) ?
                                          tpc_pkg::V4_BITS : tpc_pkg::V6_BITS))
                                == '0)
                                hit = 1'b1;
                    want.trusted = hit;
                    want.family  = pfam;
                    {want.high, want.low} = peer;
                    if (hit && it.fwd_present &&
                        (it.fwd_family == tpc_pkg::FAM_V4 ||
                         it.fwd_family == tpc_pkg::FAM_V6)) begin
                        fwd = (it.fwd_family == tpc_pkg::FAM_V4) ?
                              {96'd0, it.fwd_low[31:0]} : {it.fwd_high, it.fwd_low};
                        if (fwd != '0) begin
                            want.accepted = 1'b1;
                            want.family   = it.fwd_family;
                            {want.high, want.low} = fwd;
                            n_forwarded++;
                        end
                    end
                    if (hit)
                        n_trusted++;
                end
                default: n_unused++;
            endcase
            outstanding.push_back(want);
        endfunction

        function void check_result(input t_verdict got);
            t_verdict want;
            n_results++;
            if (outstanding.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("result %0d arrived with nothing outstanding: %s %0b %0b %0d %h_%h",
                             n_results, "acc/trusted/fam/addr", got.accepted, got.trusted,
                             got.family, got.high, got.low);
                return;
            end
            want = outstanding.pop_front();
            if (got.accepted !== want.accepted || got.trusted !== want.trusted ||
                got.family !== want.family || got.high !== want.high ||
                got.low !== want.low) begin
                n_bad++;
                if (n_bad <= 10) begin
                    $display("result %0d mismatch: expected acc=%0b trusted=%0b fam=%0d addr=%h_%h",
                             n_results, want.accepted, want.trusted, want.family, want.high,
                             want.low);
                    $display("    got acc=%0b trusted=%0b fam=%0d addr=%h_%h",
                             got.accepted, got.trusted, got.family, got.high, got.low);
                end
            end
        endfunction
    endclass

    // clock, reset and every block input start at known values
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic [1:0]  i_cmd         = '0;
    logic [1:0]  i_addr_family = '0;
    logic [63:0] i_addr_high   = '0;
    logic [63:0] i_addr_low    = '0;
    logic [7:0]  i_prefix_bits = '0;
    logic        i_fwd_present = 1'b0;
    logic [1:0]  i_fwd_family  = '0;
    logic [63:0] i_fwd_high    = '0;
    logic [63:0] i_fwd_low     = '0;
    logic        i_out_stall   = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_accepted;
    logic        o_peer_trusted;
    logic [1:0]  o_out_family;
    logic [63:0] o_out_high;
    logic [63:0] o_out_low;

    // idling odds in percent, changed between phases
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;

    cidr_scoreboard sb = new;

    // rules the stimulus believes the table holds, used to aim lookups at them
    t_cmd_item rule_pool[$];

    trusted_proxy_cidr_table u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_addr_family  (i_addr_family),
        .i_addr_high    (i_addr_high),
        .i_addr_low     (i_addr_low),
        .i_prefix_bits  (i_prefix_bits),
        .i_fwd_present  (i_fwd_present),
        .i_fwd_family   (i_fwd_family),
        .i_fwd_high     (i_fwd_high),
        .i_fwd_low      (i_fwd_low),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_accepted     (o_accepted),
        .o_peer_trusted (o_peer_trusted),
        .o_out_family   (o_out_family),
        .o_out_high     (o_out_high),
        .o_out_low      (o_out_low)
    );

    // 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver side: random stall, odds set per phase
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // both monitors sample the values from just before the edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.note_input({i_cmd, i_addr_family, i_addr_high, i_addr_low, i_prefix_bits,
                           i_fwd_present, i_fwd_family, i_fwd_high, i_fwd_low});
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result({o_accepted, o_peer_trusted, o_out_family, o_out_high, o_out_low});
    end

    // random 64-bit word with the all-zero and all-ones extremes turning up often
    function automatic logic [63:0] rand64();
        int unsigned pick;
        pick = $urandom_range(19);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return ONES;
        return {$urandom, $urandom};
    endfunction

    // offer one item, with random gaps beforehand, and hold it until taken
    task automatic send_item(input logic [1:0] cmd, input logic [1:0] fam,
                             input logic [63:0] hi, input logic [63:0] lo,
                             input logic [7:0] pfx, input logic fp, input logic [1:0] ff,
                             input logic [63:0] fh, input logic [63:0] fl);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_addr_family <= fam;
        i_addr_high   <= hi;
        i_addr_low    <= lo;
        i_prefix_bits <= pfx;
        i_fwd_present <= fp;
        i_fwd_family  <= ff;
        i_fwd_high    <= fh;
        i_fwd_low     <= fl;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    // mostly adds and lookups aimed at stored rules, with clears, junk and near misses
    task automatic run_random(input int unsigned n_items);
        t_cmd_item    r;
        t_cmd_item    rule;
        logic [127:0] a;
        logic [127:0] m;
        int unsigned  roll;
        int unsigned  w;
        int unsigned  idx;
        for (int k = 0; k < n_items; k++) begin
            // every field starts random, then gets shaped by command
            r.addr_family = 2'($urandom);
            r.addr_high   = rand64();
            r.addr_low    = rand64();
            r.prefix_bits = 8'($urandom);
            r.fwd_present = 1'($urandom);
            r.fwd_family  = 2'($urandom);
            r.fwd_high    = rand64();
            r.fwd_low     = rand64();
            roll = $urandom_range(99);
            if (roll < 4) begin
                r.cmd = tpc_pkg::CMD_CLEAR;
                rule_pool.delete();
            end else if (roll < 6) begin
                r.cmd = CMD_UNUSED;
            end else if (roll < 36) begin
                r.cmd = tpc_pkg::CMD_ADD;
                roll = $urandom_range(99);
                if (roll < 45)
                    r.addr_family = tpc_pkg::FAM_V4;
                else if (roll < 90)
                    r.addr_family = tpc_pkg::FAM_V6;
                w = (r.addr_family == tpc_pkg::FAM_V4) ? tpc_pkg::V4_BITS :
                    (r.addr_family == tpc_pkg::FAM_V6) ? tpc_pkg::V6_BITS : 0;
                // mostly legal prefix lengths, some too long
                if (w != 0 && $urandom_range(99) < 85)
                    r.prefix_bits = 8'($urandom_range(w));
                if (w != 0 && r.prefix_bits <= w && rule_pool.size() < tpc_pkg::MAX_RULES)
                    rule_pool.push_back(r);
            end else begin
                r.cmd = tpc_pkg::CMD_RESOLVE;
                if (rule_pool.size() != 0 && $urandom_range(99) < 80) begin
                    rule = rule_pool[$urandom_range(rule_pool.size() - 1)];
                    if ($urandom_range(99) < 92)
                        r.addr_family = rule.addr_family;
                    if (r.addr_family == rule.addr_family) begin
                        // keep the rule's prefix, randomise the rest (ipv4 upper bits are junk)
                        w = (rule.addr_family == tpc_pkg::FAM_V4) ? tpc_pkg::V4_BITS
                                                                   : tpc_pkg::V6_BITS;
                        m = cidr_scoreboard::lead_mask(rule.prefix_bits, w);
                        a = ({rule.addr_high, rule.addr_low} & m) | ({rand64(), rand64()} & ~m);
                        // near miss: one bit inside the prefix flipped
                        if (rule.prefix_bits != 0 && $urandom_range(99) < 25) begin
                            idx = w - 1 - $urandom_range(int'(rule.prefix_bits) - 1);
                            a[idx] = ~a[idx];
                        end
                        {r.addr_high, r.addr_low} = a;
                    end
                end
                roll = $urandom_range(99);
                if (roll < 40)
                    r.fwd_family = tpc_pkg::FAM_V4;
                else if (roll < 80)
                    r.fwd_family = tpc_pkg::FAM_V6;
                r.fwd_present = ($urandom_range(99) < 80);
                // forwarded address zero in the ipv4 part, sometimes wholly zero
                if ($urandom_range(99) < 15) begin
                    r.fwd_low[31:0] = '0;
                    if ($urandom_range(1) == 1) begin
                        r.fwd_high = '0;
                        r.fwd_low  = '0;
                    end
                end
            end
            send_item(r.cmd, r.addr_family, r.addr_high, r.addr_low, r.prefix_bits,
                      r.fwd_present, r.fwd_family, r.fwd_high, r.fwd_low);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // phase one: sender idles a little, receiver stalls a lot
        gap_pct   = 20;
        stall_pct = 67;

        // directed: empty table, then fill it with edge-case rules
        send_item(tpc_pkg::CMD_CLEAR, tpc_pkg::FAM_NONE, '0, '0, '0, 1'b0,
                  tpc_pkg::FAM_NONE, '0, '0);
        send_item(tpc_pkg::CMD_RESOLVE, tpc_pkg::FAM_V4, ONES, 64'h1234_5678_C0A8_0101, '0,
                  1'b1, tpc_pkg::FAM_V4, '0, 64'h0A00_0001);
        // ipv4 /0 with junk above bit 31: trusts every ipv4 peer
        send_item(tpc_pkg::CMD_ADD, tpc_pkg::FAM_V4, ONES, ONES, 8'd0, 1'b0,
                  tpc_pkg::FAM_NONE, '0, '0);
        send_item(tpc_pkg::CMD_ADD, tpc_pkg::FAM_V4, '0, 64'hFFFF_FFFF_C0A8_0A01, 8'd32, 1'b0,
                  tpc_pkg::FAM_NONE, '0, '0);
        // ipv4 prefix one too long
        send_item(tpc_pkg::CMD_ADD, tpc_pkg::FAM_V4, '0, 64'h0A00_0000, 8'd33, 1'b0,
                  tpc_pkg::FAM_NONE, '0, '0);
        send_item(tpc_pkg::CMD_ADD, tpc_pkg::FAM_V6, ONES, ONES, 8'd128, 1'b0,
                  tpc_pkg::FAM_NONE, '0, '0);
        // ipv6 prefix one too long
        send_item(tpc_pkg::CMD_ADD, tpc_pkg::FAM_V6, ONES, ONES, 8'd129, 1'b0,
                  tpc_pkg::FAM_NONE, '0, '0);
        // no family and the unused family code are both invalid for a rule
        send_item(tpc_pkg::CMD_ADD, tpc_pkg::FAM_NONE, ONES, ONES, 8'd8, 1'b0,
                  tpc_pkg::FAM_NONE, '0, '0);
        send_item(tpc_pkg::CMD_ADD, FAM_BAD, ONES, ONES, 8'd8, 1'b0,
                  tpc_pkg::FAM_NONE, '0, '0);
        send_item(tpc_pkg::CMD_ADD, tpc_pkg::FAM_V6, 64'h2001_0DB8_0000_0000, ONES, 8'd64,
                  1'b0, tpc_pkg::FAM_NONE, '0, '0);
        send_item(tpc_pkg::CMD_ADD, tpc_pkg::FAM_V6, 64'hFD00_0000_0000_0001,
                  64'h8000_0000_0000_0000, 8'd65, 1'b0, tpc_pkg::FAM_NONE, '0, '0);
        send_item(tpc_pkg::CMD_ADD, tpc_pkg::FAM_V4, '0, 64'hC0A8_0000, 8'd255, 1'b0,
                  tpc_pkg::FAM_NONE, '0, '0);
        send_item(tpc_pkg::CMD_ADD, tpc_pkg::FAM_V4, '0, 64'h0A01_0200, 8'd24, 1'b0,
                  tpc_pkg::FAM_NONE, '0, '0);
        send_item(tpc_pkg::CMD_ADD, tpc_pkg::FAM_V6, 64'h8000_0000_0000_0000, '0, 8'd1, 1'b0,
                  tpc_pkg::FAM_NONE, '0, '0);
        send_item(tpc_pkg::CMD_ADD, tpc_pkg::FAM_V6, '0, '0, 8'd0, 1'b0,
                  tpc_pkg::FAM_NONE, '0, '0);
        // table now full, so this valid rule is refused
        send_item(tpc_pkg::CMD_ADD, tpc_pkg::FAM_V4, '0, 64'hAC10_0000, 8'd16, 1'b0,
                  tpc_pkg::FAM_NONE, '0, '0);

        // trusted ipv4 peer with a forwarded ipv6 client
        send_item(tpc_pkg::CMD_RESOLVE, tpc_pkg::FAM_V4, ONES, 64'hFFFF_FFFF_C0A8_0A01, ONES,
                  1'b1, tpc_pkg::FAM_V6, 64'h2001_0DB8_0000_0000, 64'h1);
        // forwarded ipv4 zero once the upper junk is dropped
        send_item(tpc_pkg::CMD_RESOLVE, tpc_pkg::FAM_V4, '0, 64'h0A01_0205, '0,
                  1'b1, tpc_pkg::FAM_V4, ONES, 64'hFFFF_FFFF_0000_0000);
        // malformed forwarded family
        send_item(tpc_pkg::CMD_RESOLVE, tpc_pkg::FAM_V6, ONES, ONES, '0, 1'b1, FAM_BAD,
                  ONES, ONES);
        // forwarded address absent
        send_item(tpc_pkg::CMD_RESOLVE, tpc_pkg::FAM_V6, 64'h2001_0DB8_0000_0000, 64'h42, '0,
                  1'b0, tpc_pkg::FAM_V6, ONES, ONES);
        send_item(tpc_pkg::CMD_RESOLVE, tpc_pkg::FAM_V6, 64'h2001_0DB8_0000_0000, 64'h42, '0,
                  1'b1, tpc_pkg::FAM_NONE, ONES, ONES);
        // peer without a usable family never matches
        send_item(tpc_pkg::CMD_RESOLVE, tpc_pkg::FAM_NONE, ONES, ONES, '0, 1'b1,
                  tpc_pkg::FAM_V4, '0, 64'h0A00_0001);
        send_item(tpc_pkg::CMD_RESOLVE, FAM_BAD, ONES, ONES, '0, 1'b1, tpc_pkg::FAM_V6,
                  ONES, ONES);
        // unused command leaves the table alone
        send_item(CMD_UNUSED, tpc_pkg::FAM_V6, ONES, ONES, ONES[7:0], 1'b1, tpc_pkg::FAM_V6,
                  ONES, ONES);
        send_item(tpc_pkg::CMD_CLEAR, tpc_pkg::FAM_V4, ONES, ONES, ONES[7:0], 1'b1,
                  tpc_pkg::FAM_V4, ONES, ONES);
        // cleared table: forwarded address ignored
        send_item(tpc_pkg::CMD_RESOLVE, tpc_pkg::FAM_V6, ONES, ONES, '0, 1'b1,
                  tpc_pkg::FAM_V4, ONES, ONES);

        run_random(580);

        // phase two: sender idles a lot, receiver stalls a little
        gap_pct   = 67;
        stall_pct = 20;
        run_random(580);

        // phase three: full rate on both sides
        gap_pct   = 0;
        stall_pct = 0;
        run_random(590);

        i_in_valid <= 1'b0;
        while (sb.outstanding.size() != 0)
            @(posedge i_clk);
        // allow for a stray late result
        repeat (24) @(posedge i_clk);

        $display("covered %0d clears, %0d adds (%0d stored), %0d unused commands",
                 sb.n_clear, sb.n_add, sb.n_stored, sb.n_unused);
        $display("covered %0d lookups: %0d trusted, %0d forwarded; %0d results, %0d mismatches",
                 sb.n_resolve, sb.n_trusted, sb.n_forwarded, sb.n_results, sb.n_bad);
        if (sb.n_bad == 0 && sb.outstanding.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", sb.outstanding.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
